[sv/bcl_pkg.sv]
// shared types and constants for the block cache
`default_nettype none
package bcl_pkg;

    localparam int DEF_MAX_ENTRIES     = 256;
    localparam int DEF_BLOCK_WORDS     = 32;
    localparam int DEF_NUM_DISKS       = 16;
    localparam int DEF_BLOCKS_PER_DISK = 256;

    // slot numbers carried in the scan token, wide enough for the largest cache
    localparam int IDX_MAX_W = 12;

    localparam logic [1:0] MODE_LOOKUP = 2'd0;
    localparam logic [1:0] MODE_INSERT = 2'd1;
    localparam logic [1:0] MODE_UPDATE = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_MISS   = 2'd1;
    localparam logic [1:0] ST_REJECT = 2'd2;

    localparam logic [1:0] CFG_ENABLE  = 2'd0;
    localparam logic [1:0] CFG_ENTRIES = 2'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_READ,
        S_WAIT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic                 vld;
        logic                 hit;
        logic [IDX_MAX_W-1:0] hit_idx;
        logic                 free;
        logic [IDX_MAX_W-1:0] free_idx;
        logic [IDX_MAX_W-1:0] best_idx;
        logic [31:0]          best_stamp;
    } t_tok;

    typedef struct packed {
        logic                 clr;
        logic                 we;
        logic [IDX_MAX_W-1:0] idx;
        logic                 load_tags;
        logic [3:0]           disk;
        logic [7:0]           blk;
        logic                 stamp_load;
        logic                 stamp_inc;
        logic [31:0]          stamp_val;
    } t_cmd;

endpackage
`default_nettype wire

[sv/bcl_cell.sv]
// one cache entry: tags, stamp and a stage of the scan token
`default_nettype none
module bcl_cell #(
    parameter int MAX_ENTRIES = bcl_pkg::DEF_MAX_ENTRIES,
    parameter int INDEX       = 0,
    localparam int LW         = $clog2(MAX_ENTRIES + 1)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire bcl_pkg::t_tok i_tok,
    output bcl_pkg::t_tok      o_tok,
    input  wire bcl_pkg::t_cmd i_cmd,
    input  wire logic [3:0]    i_disk,
    input  wire logic [7:0]    i_block,
    input  wire logic [LW-1:0] i_live
);

    localparam logic [bcl_pkg::IDX_MAX_W-1:0] MY_IDX = bcl_pkg::IDX_MAX_W'(INDEX);

    logic          r_valid;
    logic [3:0]    r_disk;
    logic [7:0]    r_block;
    logic [31:0]   r_stamp;
    bcl_pkg::t_tok r_tok;
    bcl_pkg::t_tok n_tok;
    logic          w_active;
    logic          w_sel;

    assign w_active = LW'(INDEX) < i_live;
    assign w_sel    = i_cmd.we && (i_cmd.idx == MY_IDX);

    always_comb begin
        n_tok = i_tok;
        if (i_tok.vld && w_active) begin
            if (r_valid && r_disk == i_disk && r_block == i_block && !i_tok.hit) begin
                n_tok.hit     = 1'b1;
                n_tok.hit_idx = MY_IDX;
            end
            if (!r_valid && !i_tok.free) begin
                n_tok.free     = 1'b1;
                n_tok.free_idx = MY_IDX;
            end
            // ties go to the later entry
            if (INDEX == 0 || r_stamp <= i_tok.best_stamp) begin
                n_tok.best_idx   = MY_IDX;
                n_tok.best_stamp = r_stamp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_tok <= n_tok;
            if (i_cmd.clr) begin
                r_valid <= 1'b0;
            end else if (w_sel && i_cmd.load_tags) begin
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_sel) begin
            if (i_cmd.load_tags) begin
                r_disk  <= i_cmd.disk;
                r_block <= i_cmd.blk;
            end
            if (i_cmd.stamp_load) begin
                r_stamp <= i_cmd.stamp_val;
            end else if (i_cmd.stamp_inc) begin
                r_stamp <= r_stamp + 32'd1;
            end
        end
    end

    assign o_tok = r_tok;

endmodule
`default_nettype wire

[sv/bcl_chain.sv]
// row of entry cells that the scan token walks through
`default_nettype none
module bcl_chain #(
    parameter int MAX_ENTRIES = bcl_pkg::DEF_MAX_ENTRIES,
    localparam int LW         = $clog2(MAX_ENTRIES + 1)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire bcl_pkg::t_tok i_tok,
    output bcl_pkg::t_tok      o_tok,
    input  wire bcl_pkg::t_cmd i_cmd,
    input  wire logic [3:0]    i_disk,
    input  wire logic [7:0]    i_block,
    input  wire logic [LW-1:0] i_live
);

    bcl_pkg::t_tok w_tok [MAX_ENTRIES+1];

    assign w_tok[0] = i_tok;

    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        bcl_cell #(
            .MAX_ENTRIES(MAX_ENTRIES),
            .INDEX      (g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_tok  (w_tok[g]),
            .o_tok  (w_tok[g+1]),
            .i_cmd  (i_cmd),
            .i_disk (i_disk),
            .i_block(i_block),
            .i_live (i_live)
        );
    end

    assign o_tok = w_tok[MAX_ENTRIES];

endmodule
`default_nettype wire

[sv/block_cache_lru.sv]
// top level of the fully associative block cache with lru replacement
`default_nettype none
// Fully associative cache of disk blocks. A lookup, or word 0 of an insert or update,
// sends a token down a row of MAX_ENTRIES entry cells, one cell per cycle, through
// every cell whatever the number of entries in use. A lookup hit then streams
// BLOCK_WORDS beats, each through the S_READ, S_WAIT and S_OUT states of the
// block memory read plus the wait for o_out_ready. Later words of an insert or
// update, and every request rejected when it is taken, answer in the cycle after
// they are taken. One request is in the block at a time. After reset and after
// a write to CFG_ENABLE or CFG_ENTRIES the block memory is zeroed one word per
// cycle while o_in_ready and o_cfg_ready stay low; such a configuration write
// also empties the cache.
module block_cache_lru #(
    parameter int MAX_ENTRIES     = bcl_pkg::DEF_MAX_ENTRIES,
    parameter int BLOCK_WORDS     = bcl_pkg::DEF_BLOCK_WORDS,
    parameter int NUM_DISKS       = bcl_pkg::DEF_NUM_DISKS,
    parameter int BLOCKS_PER_DISK = bcl_pkg::DEF_BLOCKS_PER_DISK
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [8:0]  i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_mode,
    input  wire logic [3:0]  i_disk_id,
    input  wire logic [7:0]  i_block_id,
    input  wire logic [4:0]  i_word_index,
    input  wire logic [63:0] i_data_in,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_status,
    output logic [63:0]      o_data_out,
    output logic [4:0]       o_out_index,
    output logic             o_last
);

    localparam int LW    = $clog2(MAX_ENTRIES + 1);
    localparam int IW    = $clog2(MAX_ENTRIES);
    localparam int KW    = (BLOCK_WORDS > 1) ? $clog2(BLOCK_WORDS) : 1;
    localparam int DEPTH = MAX_ENTRIES * BLOCK_WORDS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = (LW > 9) ? LW : 9;

    bcl_pkg::t_state r_state, n_state;

    logic          r_en, n_en;
    logic [8:0]    r_entries, n_entries;
    logic [31:0]   r_clock, n_clock;
    logic [IW-1:0] r_pslot, n_pslot;
    logic [1:0]    r_pout, n_pout;
    logic [IW-1:0] r_sslot, n_sslot;
    logic [KW-1:0] r_k, n_k;
    logic          r_start, n_start;
    logic          r_clr, n_clr;
    logic [AW-1:0] r_caddr, n_caddr;

    logic [1:0]    r_mode, n_mode;
    logic [3:0]    r_disk, n_disk;
    logic [7:0]    r_block, n_block;
    logic [4:0]    r_w, n_w;
    logic [63:0]   r_din, n_din;

    logic          r_ov, n_ov;
    logic [1:0]    r_status, n_status;
    logic [63:0]   r_dout, n_dout;
    logic [4:0]    r_oidx, n_oidx;
    logic          r_last, n_last;

    logic [63:0]   r_rd;
    logic [63:0]   r_mem [DEPTH];

    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [63:0]   w_wdata;
    logic          w_re;
    logic [AW-1:0] w_raddr;

    logic          w_accept;
    logic          w_ids_ok;
    logic [CW-1:0] w_ent_ext;
    logic [LW-1:0] w_live;

    bcl_pkg::t_tok w_tok_in;
    bcl_pkg::t_tok w_tok_out;
    bcl_pkg::t_cmd w_cmd;

    assign o_cfg_ready = !r_clr;
    assign o_in_ready  = (r_state == bcl_pkg::S_IDLE) && !r_ov && !r_clr;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_ids_ok    = (32'(i_disk_id) < NUM_DISKS) && (32'(i_block_id) < BLOCKS_PER_DISK);

    assign w_ent_ext = CW'(r_entries);
    assign w_live    = (w_ent_ext < CW'(2)) ? LW'(2) :
                       (w_ent_ext > CW'(MAX_ENTRIES)) ? LW'(MAX_ENTRIES) : LW'(w_ent_ext);

    always_comb begin
        w_tok_in     = '0;
        w_tok_in.vld = r_start;
    end

    bcl_chain #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) u_chain (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_tok  (w_tok_in),
        .o_tok  (w_tok_out),
        .i_cmd  (w_cmd),
        .i_disk (r_disk),
        .i_block(r_block),
        .i_live (w_live)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            bcl_pkg::S_IDLE: begin
                if (n_start) begin
                    n_state = bcl_pkg::S_SCAN;
                end
            end
            bcl_pkg::S_SCAN: begin
                if (w_tok_out.vld) begin
                    if (r_mode == bcl_pkg::MODE_LOOKUP && w_tok_out.hit) begin
                        n_state = bcl_pkg::S_READ;
                    end else begin
                        n_state = bcl_pkg::S_IDLE;
                    end
                end
            end
            bcl_pkg::S_READ: n_state = bcl_pkg::S_WAIT;
            bcl_pkg::S_WAIT: n_state = bcl_pkg::S_OUT;
            bcl_pkg::S_OUT: begin
                if (r_ov && i_out_ready) begin
                    n_state = r_last ? bcl_pkg::S_IDLE : bcl_pkg::S_READ;
                end
            end
            default: n_state = bcl_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        logic [1:0]    po;
        logic [IW-1:0] s;
        po        = r_pout;
        s         = r_pslot;
        n_en      = r_en;
        n_entries = r_entries;
        n_clock   = r_clock;
        n_pslot   = r_pslot;
        n_pout    = r_pout;
        n_sslot   = r_sslot;
        n_k       = r_k;
        n_start   = 1'b0;
        n_clr     = r_clr;
        n_caddr   = r_caddr;
        n_mode    = r_mode;
        n_disk    = r_disk;
        n_block   = r_block;
        n_w       = r_w;
        n_din     = r_din;
        n_ov      = r_ov;
        n_status  = r_status;
        n_dout    = r_dout;
        n_oidx    = r_oidx;
        n_last    = r_last;
        w_we      = 1'b0;
        w_waddr   = '0;
        w_wdata   = r_din;
        w_re      = 1'b0;
        w_raddr   = '0;
        w_cmd     = '0;

        if (r_ov && i_out_ready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            bcl_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_mode  = i_mode;
                    n_disk  = i_disk_id;
                    n_block = i_block_id;
                    n_w     = i_word_index;
                    n_din   = i_data_in;
                    n_dout  = '0;
                    n_last  = 1'b1;
                    if (!r_en || (i_mode != bcl_pkg::MODE_LOOKUP &&
                                  i_mode != bcl_pkg::MODE_INSERT &&
                                  i_mode != bcl_pkg::MODE_UPDATE)) begin
                        n_ov     = 1'b1;
                        n_status = bcl_pkg::ST_REJECT;
                        n_oidx   = (i_mode == bcl_pkg::MODE_LOOKUP) ? 5'd0 : i_word_index;
                    end else if (i_mode == bcl_pkg::MODE_LOOKUP) begin
                        if (!w_ids_ok) begin
                            n_ov     = 1'b1;
                            n_status = bcl_pkg::ST_REJECT;
                            n_oidx   = 5'd0;
                        end else begin
                            n_start = 1'b1;
                        end
                    end else if (i_word_index != 5'd0) begin
                        po     = w_ids_ok ? r_pout : bcl_pkg::ST_REJECT;
                        n_pout = po;
                        if (po == bcl_pkg::ST_OK && 32'(i_word_index) < BLOCK_WORDS) begin
                            w_we    = 1'b1;
                            w_waddr = AW'(r_pslot) * AW'(BLOCK_WORDS) + AW'(i_word_index);
                            w_wdata = i_data_in;
                        end
                        n_ov     = 1'b1;
                        n_status = po;
                        n_oidx   = i_word_index;
                    end else if (!w_ids_ok) begin
                        n_pout   = bcl_pkg::ST_REJECT;
                        n_ov     = 1'b1;
                        n_status = bcl_pkg::ST_REJECT;
                        n_oidx   = i_word_index;
                    end else begin
                        n_start = 1'b1;
                    end
                end
            end
            bcl_pkg::S_SCAN: begin
                if (w_tok_out.vld) begin
                    n_dout = '0;
                    n_last = 1'b1;
                    if (r_mode == bcl_pkg::MODE_LOOKUP) begin
                        if (w_tok_out.hit) begin
                            w_cmd.we         = 1'b1;
                            w_cmd.idx        = w_tok_out.hit_idx;
                            w_cmd.stamp_load = 1'b1;
                            w_cmd.stamp_val  = r_clock;
                            n_clock          = r_clock + 32'd1;
                            n_sslot          = w_tok_out.hit_idx[IW-1:0];
                            n_k              = '0;
                        end else begin
                            n_ov     = 1'b1;
                            n_status = bcl_pkg::ST_MISS;
                            n_oidx   = 5'd0;
                        end
                    end else begin
                        if (r_mode == bcl_pkg::MODE_INSERT) begin
                            if (w_tok_out.hit) begin
                                po = bcl_pkg::ST_REJECT;
                            end else begin
                                s = w_tok_out.free ? w_tok_out.free_idx[IW-1:0]
                                                   : w_tok_out.best_idx[IW-1:0];
                                w_cmd.we         = 1'b1;
                                w_cmd.idx        = bcl_pkg::IDX_MAX_W'(s);
                                w_cmd.load_tags  = 1'b1;
                                w_cmd.disk       = r_disk;
                                w_cmd.blk        = r_block;
                                w_cmd.stamp_load = 1'b1;
                                w_cmd.stamp_val  = r_clock;
                                n_clock          = r_clock + 32'd1;
                                w_we             = 1'b1;
                                w_waddr          = AW'(s) * AW'(BLOCK_WORDS);
                                n_pslot          = s;
                                po               = bcl_pkg::ST_OK;
                            end
                        end else begin
                            if (!w_tok_out.hit) begin
                                po = bcl_pkg::ST_MISS;
                            end else begin
                                s               = w_tok_out.hit_idx[IW-1:0];
                                w_cmd.we        = 1'b1;
                                w_cmd.idx       = w_tok_out.hit_idx;
                                w_cmd.stamp_inc = 1'b1;
                                n_clock         = r_clock + 32'd1;
                                w_we            = 1'b1;
                                w_waddr         = AW'(s) * AW'(BLOCK_WORDS);
                                n_pslot         = s;
                                po              = bcl_pkg::ST_OK;
                            end
                        end
                        n_pout   = po;
                        n_ov     = 1'b1;
                        n_status = po;
                        n_oidx   = r_w;
                    end
                end
            end
            bcl_pkg::S_READ: begin
                w_re    = 1'b1;
                w_raddr = AW'(r_sslot) * AW'(BLOCK_WORDS) + AW'(r_k);
            end
            bcl_pkg::S_WAIT: begin
                n_ov     = 1'b1;
                n_status = bcl_pkg::ST_OK;
                n_dout   = r_rd;
                n_oidx   = 5'(r_k);
                n_last   = (32'(r_k) == BLOCK_WORDS - 1);
            end
            bcl_pkg::S_OUT: begin
                if (r_ov && i_out_ready && !r_last) begin
                    n_k = r_k + KW'(1);
                end
            end
            default: begin
                n_ov = 1'b0;
            end
        endcase

        // zero the block memory one word per cycle
        if (r_clr) begin
            w_we    = 1'b1;
            w_waddr = r_caddr;
            w_wdata = '0;
            n_caddr = r_caddr + AW'(1);
            if (r_caddr == AW'(DEPTH - 1)) begin
                n_clr = 1'b0;
            end
        end

        // a write to CFG_ENABLE or CFG_ENTRIES empties the cache
        if (i_cfg_valid && o_cfg_ready &&
            (i_cfg_index == bcl_pkg::CFG_ENABLE || i_cfg_index == bcl_pkg::CFG_ENTRIES)) begin
            if (i_cfg_index == bcl_pkg::CFG_ENABLE) begin
                n_en = i_cfg_data[0];
            end else begin
                n_entries = i_cfg_data;
            end
            w_cmd.clr = 1'b1;
            n_clock   = '0;
            n_pslot   = '0;
            n_pout    = bcl_pkg::ST_OK;
            n_clr     = 1'b1;
            n_caddr   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= bcl_pkg::S_IDLE;
            r_en      <= 1'b0;
            r_entries <= 9'(MAX_ENTRIES);
            r_clock   <= '0;
            r_pslot   <= '0;
            r_pout    <= bcl_pkg::ST_OK;
            r_start   <= 1'b0;
            r_clr     <= 1'b1;
            r_caddr   <= '0;
            r_ov      <= 1'b0;
            r_k       <= '0;
        end else begin
            r_state   <= n_state;
            r_en      <= n_en;
            r_entries <= n_entries;
            r_clock   <= n_clock;
            r_pslot   <= n_pslot;
            r_pout    <= n_pout;
            r_start   <= n_start;
            r_clr     <= n_clr;
            r_caddr   <= n_caddr;
            r_ov      <= n_ov;
            r_k       <= n_k;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sslot  <= n_sslot;
        r_mode   <= n_mode;
        r_disk   <= n_disk;
        r_block  <= n_block;
        r_w      <= n_w;
        r_din    <= n_din;
        r_status <= n_status;
        r_dout   <= n_dout;
        r_oidx   <= n_oidx;
        r_last   <= n_last;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rd <= r_mem[w_raddr];
        end
    end

    assign o_out_valid = r_ov;
    assign o_status    = r_status;
    assign o_data_out  = r_dout;
    assign o_out_index = r_oidx;
    assign o_last      = r_last;

    a_tok_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tok_out.vld |-> r_state == bcl_pkg::S_SCAN)
        else $error("scan token left the chain outside a scan");

    a_stream_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bcl_pkg::S_OUT && r_ov && i_out_ready && r_last)
        |=> r_state == bcl_pkg::S_IDLE)
        else $error("stream did not finish after its last beat");

    a_word_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == bcl_pkg::S_READ |-> 32'(r_k) < BLOCK_WORDS)
        else $error("streamed word index beyond the block");

    a_mem_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == bcl_pkg::S_IDLE || r_state == bcl_pkg::S_SCAN))
        else $error("block write while streaming");

endmodule
`default_nettype wire

[tb/block_cache_lru_checker.sv]
// checker for the block cache: predicts every result beat and compares it with the output
`default_nettype none
module block_cache_lru_checker #(
    parameter int MAX_ENTRIES = bcl_pkg::DEF_MAX_ENTRIES,
    parameter int BLOCK_WORDS = bcl_pkg::DEF_BLOCK_WORDS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    input  wire logic        i_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [8:0]  i_cfg_data,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire logic [1:0]  i_mode,
    input  wire logic [3:0]  i_disk_id,
    input  wire logic [7:0]  i_block_id,
    input  wire logic [4:0]  i_word_index,
    input  wire logic [63:0] i_data_in,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [1:0]  i_status,
    input  wire logic [63:0] i_data_out,
    input  wire logic [4:0]  i_out_index,
    input  wire logic        i_last,
    output int               o_fail_count,
    output int               o_pending
);

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] data;
        logic [4:0]  index;
        logic        last;
    } t_beat;

    t_beat       beat_queue[$];
    logic        enabled;
    logic [8:0]  entries_cfg;
    logic        slot_valid[MAX_ENTRIES];
    logic [3:0]  slot_disk[MAX_ENTRIES];
    logic [7:0]  slot_block[MAX_ENTRIES];
    logic [31:0] slot_stamp[MAX_ENTRIES];
    logic [63:0] slot_words[MAX_ENTRIES][BLOCK_WORDS];
    logic [31:0] stamp_now;
    int          held_slot;
    logic [1:0]  held_outcome;

    assign o_pending = beat_queue.size();

    task automatic wipe_cache();
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            slot_valid[i] = 1'b0;
            slot_stamp[i] = '0;
            for (int k = 0; k < BLOCK_WORDS; k++) slot_words[i][k] = '0;
        end
        stamp_now = '0;
        held_slot = 0;
        held_outcome = bcl_pkg::ST_OK;
    endtask

    function automatic int scan_limit();
        if (entries_cfg < 2) return 2;
        if (entries_cfg > MAX_ENTRIES) return MAX_ENTRIES;
        return int'(entries_cfg);
    endfunction

    function automatic int find_slot(logic [3:0] d, logic [7:0] b);
        for (int i = 0; i < scan_limit(); i++)
            if (slot_valid[i] && slot_disk[i] == d && slot_block[i] == b) return i;
        return -1;
    endfunction

    function automatic int victim_slot();
        int best;
        best = 0;
        for (int i = 0; i < scan_limit(); i++)
            if (!slot_valid[i]) return i;
        for (int i = 1; i < scan_limit(); i++)
            if (slot_stamp[i] <= slot_stamp[best]) best = i;
        return best;
    endfunction

    task automatic push_beat(logic [1:0] st, logic [63:0] dat, logic [4:0] idx, logic lst);
        t_beat b;
        b.status = st;
        b.data = dat;
        b.index = idx;
        b.last = lst;
        beat_queue.push_back(b);
    endtask

    task automatic predict_request(logic [1:0] mode, logic [3:0] d, logic [7:0] b,
                                   logic [4:0] w, logic [63:0] dat);
        int hit;
        int s;
        if (!enabled || !(mode inside {bcl_pkg::MODE_LOOKUP, bcl_pkg::MODE_INSERT,
                                       bcl_pkg::MODE_UPDATE})) begin
            push_beat(bcl_pkg::ST_REJECT, '0, (mode == bcl_pkg::MODE_LOOKUP) ? 5'd0 : w, 1'b1);
        end else if (mode == bcl_pkg::MODE_LOOKUP) begin
            hit = find_slot(d, b);
            if (hit < 0) begin
                push_beat(bcl_pkg::ST_MISS, '0, '0, 1'b1);
            end else begin
                for (int k = 0; k < BLOCK_WORDS; k++)
                    push_beat(bcl_pkg::ST_OK, slot_words[hit][k], k[4:0],
                              k == BLOCK_WORDS - 1);
                slot_stamp[hit] = stamp_now;
                stamp_now++;
            end
        end else if (w != 0) begin
            if (held_outcome == bcl_pkg::ST_OK && w < BLOCK_WORDS)
                slot_words[held_slot][w] = dat;
            push_beat(held_outcome, '0, w, 1'b1);
        end else begin
            if (mode == bcl_pkg::MODE_INSERT) begin
                if (find_slot(d, b) >= 0) begin
                    held_outcome = bcl_pkg::ST_REJECT;
                end else begin
                    s = victim_slot();
                    slot_valid[s] = 1'b1;
                    slot_disk[s] = d;
                    slot_block[s] = b;
                    slot_stamp[s] = stamp_now;
                    stamp_now++;
                    slot_words[s][0] = dat;
                    held_slot = s;
                    held_outcome = bcl_pkg::ST_OK;
                end
            end else begin
                hit = find_slot(d, b);
                if (hit < 0) begin
                    held_outcome = bcl_pkg::ST_MISS;
                end else begin
                    stamp_now++;
                    slot_stamp[hit]++;
                    slot_words[hit][0] = dat;
                    held_slot = hit;
                    held_outcome = bcl_pkg::ST_OK;
                end
            end
            push_beat(held_outcome, '0, w, 1'b1);
        end
    endtask

    always @(posedge i_clk) begin
        t_beat exp_beat;
        if (!i_rst_n) begin
            enabled = 1'b0;
            entries_cfg = 9'd256;
            wipe_cache();
            beat_queue.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == bcl_pkg::CFG_ENABLE) begin
                    enabled = i_cfg_data[0];
                    wipe_cache();
                end else if (i_cfg_index == bcl_pkg::CFG_ENTRIES) begin
                    entries_cfg = i_cfg_data;
                    wipe_cache();
                end
            end
            if (i_in_valid && i_in_ready)
                predict_request(i_mode, i_disk_id, i_block_id, i_word_index, i_data_in);
            if (i_out_valid && i_out_ready) begin
                if (beat_queue.size() == 0) begin
                    $error("unexpected result beat: status %0d", i_status);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_beat = beat_queue.pop_front();
                    if (exp_beat != {i_status, i_data_out, i_out_index, i_last}) begin
                        if (exp_beat.status != i_status)
                            $error("status: expected %0d, got %0d", exp_beat.status, i_status);
                        if (exp_beat.data != i_data_out)
                            $error("data_out: expected %h, got %h", exp_beat.data, i_data_out);
                        if (exp_beat.index != i_out_index)
                            $error("out_index: expected %0d, got %0d",
                                   exp_beat.index, i_out_index);
                        if (exp_beat.last != i_last)
                            $error("last: expected %0d, got %0d", exp_beat.last, i_last);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule
`default_nettype wire

[tb/tb_block_cache_lru.sv]
// testbench top for the block cache: stimulus, configuration phases and verdict
`default_nettype none
module tb_block_cache_lru;

    localparam int WATCHDOG_LIMIT = 40000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [8:0]  i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_mode;
    logic [3:0]  i_disk_id;
    logic [7:0]  i_block_id;
    logic [4:0]  i_word_index;
    logic [63:0] i_data_in;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [1:0]  o_status;
    logic [63:0] o_data_out;
    logic [4:0]  o_out_index;
    logic        o_last;
    int          fail_count;
    int          beats_pending;
    int          idle_cycles;
    logic [3:0]  hot_disk[8];
    logic [7:0]  hot_block[8];

    block_cache_lru uut (.*);

    block_cache_lru_checker checker_i (
        .i_clk, .i_rst_n, .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index,
        .i_cfg_data, .i_in_valid, .i_in_ready(o_in_ready), .i_mode, .i_disk_id,
        .i_block_id, .i_word_index, .i_data_in, .i_out_valid(o_out_valid),
        .i_out_ready, .i_status(o_status), .i_data_out(o_data_out),
        .i_out_index(o_out_index), .i_last(o_last), .o_fail_count(fail_count),
        .o_pending(beats_pending)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // watchdog on cycles with no beat moving anywhere
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // receiver holds off ready at random before each beat
    initial begin
        int gap;
        i_out_ready = 1'b0;
        forever begin
            gap = $urandom_range(0, 5);
            if ($urandom_range(0, 3) == 0) gap = 0;
            repeat (gap) @(posedge i_clk);
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            i_out_ready <= 1'b0;
        end
    end

    task automatic send_request(logic [1:0] mode, logic [3:0] d, logic [7:0] b,
                                logic [4:0] w, logic [63:0] dat);
        repeat ($urandom_range(0, 5)) @(posedge i_clk);
        i_in_valid <= 1'b1;
        i_mode <= mode;
        i_disk_id <= d;
        i_block_id <= b;
        i_word_index <= w;
        i_data_in <= dat;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    task automatic send_block(logic [1:0] mode, logic [3:0] d, logic [7:0] b);
        for (int k = 0; k < bcl_pkg::DEF_BLOCK_WORDS; k++)
            send_request(mode, d, b, k[4:0], {$urandom, $urandom});
    endtask

    task automatic write_reg(logic [1:0] idx, logic [8:0] val);
        while (beats_pending != 0) @(posedge i_clk);
        // a write burst with no result beat may still be scanning
        repeat (bcl_pkg::DEF_MAX_ENTRIES + 8) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(int count);
        int pick;
        int n;
        for (int i = 0; i < 8; i++) begin
            hot_disk[i] = 4'($urandom);
            hot_block[i] = 8'($urandom);
        end
        n = 0;
        while (n < count) begin
            pick = $urandom_range(0, 7);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    send_request(bcl_pkg::MODE_LOOKUP, hot_disk[pick], hot_block[pick],
                                 5'($urandom), {$urandom, $urandom});
                    n++;
                end
                4, 5: begin
                    send_block(bcl_pkg::MODE_INSERT, hot_disk[pick], hot_block[pick]);
                    n += bcl_pkg::DEF_BLOCK_WORDS;
                end
                6: begin
                    send_block(bcl_pkg::MODE_UPDATE, hot_disk[pick], hot_block[pick]);
                    n += bcl_pkg::DEF_BLOCK_WORDS;
                end
                default: begin
                    // noise: any mode, any field, broken bursts
                    send_request(2'($urandom), 4'($urandom), 8'($urandom), 5'($urandom),
                                 {$urandom, $urandom});
                    n++;
                end
            endcase
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = bcl_pkg::CFG_ENABLE;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_mode = bcl_pkg::MODE_LOOKUP;
        i_disk_id = '0;
        i_block_id = '0;
        i_word_index = '0;
        i_data_in = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // disabled cache rejects every mode
        send_request(bcl_pkg::MODE_LOOKUP, 4'd1, 8'd2, 5'd7, '1);
        send_request(bcl_pkg::MODE_INSERT, 4'd1, 8'd2, 5'd0, '1);
        send_request(bcl_pkg::MODE_UPDATE, 4'd1, 8'd2, 5'd3, '0);
        send_request(bcl_pkg::MODE_UNUSED, 4'd15, 8'd255, 5'd31, '1);

        write_reg(bcl_pkg::CFG_ENTRIES, 9'd2);
        write_reg(bcl_pkg::CFG_ENABLE, 9'd1);
        send_request(bcl_pkg::MODE_LOOKUP, 4'd0, 8'd0, 5'd0, '0);
        send_request(bcl_pkg::MODE_UPDATE, 4'd0, 8'd0, 5'd0, '1);
        send_request(bcl_pkg::MODE_UPDATE, 4'd0, 8'd0, 5'd31, '1);
        send_request(bcl_pkg::MODE_INSERT, 4'd15, 8'd255, 5'd0, '1);
        send_request(bcl_pkg::MODE_INSERT, 4'd15, 8'd255, 5'd31, 64'h0123_4567_89ab_cdef);
        send_request(bcl_pkg::MODE_INSERT, 4'd15, 8'd255, 5'd0, '0);
        send_request(bcl_pkg::MODE_INSERT, 4'd0, 8'd0, 5'd0, 64'h5555_aaaa_5555_aaaa);
        send_request(bcl_pkg::MODE_LOOKUP, 4'd15, 8'd255, 5'd0, '0);
        // both slots full: next insert evicts
        send_request(bcl_pkg::MODE_INSERT, 4'd7, 8'd128, 5'd0, 64'haaaa_5555_aaaa_5555);
        send_request(bcl_pkg::MODE_LOOKUP, 4'd0, 8'd0, 5'd0, '0);
        send_request(bcl_pkg::MODE_LOOKUP, 4'd7, 8'd128, 5'd0, '0);
        send_request(bcl_pkg::MODE_UNUSED, 4'd0, 8'd0, 5'd5, '0);
        random_phase(80);

        write_reg(bcl_pkg::CFG_ENTRIES, 9'd0);
        random_phase(50);
        write_reg(bcl_pkg::CFG_ENTRIES, 9'd511);
        random_phase(70);
        write_reg(bcl_pkg::CFG_ENTRIES, 9'd256);
        random_phase(70);
        write_reg(bcl_pkg::CFG_ENTRIES, 9'd5);
        random_phase(50);
        write_reg(bcl_pkg::CFG_ENABLE, 9'd0);
        random_phase(10);

        while (beats_pending != 0) @(posedge i_clk);
        repeat (bcl_pkg::DEF_MAX_ENTRIES + 8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
`default_nettype wire
